@@ rtl/core/zlib_stream_integrity_checker_unit_assert.svh @@
// Assertion macros used by the checker file.
`ifndef ZLIB_STREAM_INTEGRITY_CHECKER_UNIT_ASSERT_SVH
`define ZLIB_STREAM_INTEGRITY_CHECKER_UNIT_ASSERT_SVH

// Implication in the same cycle, masked while reset is high.
`define ZSIC_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Implication in the next cycle, masked while reset is high.
`define ZSIC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

// Implication in the next cycle, always checked (used for reset behaviour).
`define ZSIC_ASSERT_ALWAYS_NEXT(label, clk, ante, cons, msg) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/core/zsic_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package zsic_pkg;

   localparam int FUNC_W          = 2;
   localparam int BYTE_W          = 8;
   localparam int WORD_W          = 32;
   localparam int STATUS_W        = 2;
   localparam int SUM_W           = 16;
   localparam int STREAM_W        = 25;
   localparam int TOTAL_W         = 29;
   localparam int CSR_DATA_W      = 29;
   localparam int CSR_INDEX_W     = 1;

   localparam logic [SUM_W:0]      ADLER_MOD          = 17'd65521;
   localparam int                  HDR_CHECK_DIV      = 31;
   localparam logic [3:0]          DEFLATE_METHOD     = 4'd8;
   localparam logic [3:0]          MAX_WINDOW_INFO    = 4'd7;
   localparam logic [7:0]          PRESET_DICT_MASK   = 8'd32;
   localparam logic [WORD_W-1:0]   MIN_CODED_LENGTH   = 32'd6;
   localparam logic [STREAM_W-1:0] STREAM_LIMIT_RESET = 25'd4194304;
   localparam logic [TOTAL_W-1:0]  TOTAL_LIMIT_RESET  = 29'd33554432;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_START = 2'd0,
      FUNC_DATA  = 2'd1,
      FUNC_END   = 2'd2
   } func_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK          = 2'd0,
      STATUS_LIMIT       = 2'd1,
      STATUS_UNSUPPORTED = 2'd2,
      STATUS_INVALID     = 2'd3
   } status_type;

   localparam logic [CSR_INDEX_W-1:0] CSR_STREAM_BYTE_LIMIT = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_TOTAL_BYTE_LIMIT  = 1'd1;

   // Header word is cmf*256 + flg; 256 = 8 (mod 31) and 32 = 1 (mod 31), so fold
   // to cmf*8 + flg and then add 5-bit digits.
   function automatic logic header_ok(input logic [7:0] cmf, input logic [7:0] flg);
      logic [11:0] folded;
      logic [6:0]  digits;
      logic        div_ok;
      folded = {1'b0, cmf, 3'b000} + {4'b0000, flg};
      digits = {2'b00, folded[4:0]} + {2'b00, folded[9:5]} + {5'b00000, folded[11:10]};
      div_ok = (digits == 7'd0) || (digits == 7'(HDR_CHECK_DIV))
            || (digits == 7'(2 * HDR_CHECK_DIV));
      return (cmf[3:0] == DEFLATE_METHOD) && (cmf[7:4] <= MAX_WINDOW_INFO)
          && div_ok && ((flg & PRESET_DICT_MASK) == 8'd0);
   endfunction

endpackage

`default_nettype wire

@@ rtl/core/zsic_req_if.sv @@
`timescale 1ns / 1ps
`default_nettype none

interface zsic_req_if;
   logic                             valid;
   logic                             ready;
   logic [zsic_pkg::FUNC_W-1:0]      func;
   logic [7:0]                       header_cmf;
   logic [7:0]                       header_flg;
   logic                             is_compressed;
   logic [zsic_pkg::WORD_W-1:0]      coded_length;
   logic [zsic_pkg::BYTE_W-1:0]      data_byte;
   logic [zsic_pkg::WORD_W-1:0]      trailer_word;

   modport source (
      output valid, func, header_cmf, header_flg, is_compressed, coded_length,
             data_byte, trailer_word,
      input  ready
   );

   modport sink (
      input  valid, func, header_cmf, header_flg, is_compressed, coded_length,
             data_byte, trailer_word,
      output ready
   );
endinterface

`default_nettype wire

@@ rtl/core/zsic_rsp_if.sv @@
`timescale 1ns / 1ps
`default_nettype none

interface zsic_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [zsic_pkg::STATUS_W-1:0]  status;
   logic [zsic_pkg::WORD_W-1:0]    checksum;
   logic [zsic_pkg::STREAM_W-1:0]  stream_bytes;
   logic [zsic_pkg::TOTAL_W-1:0]   total_bytes;

   modport source (
      output valid, status, checksum, stream_bytes, total_bytes,
      input  ready
   );

   modport sink (
      input  valid, status, checksum, stream_bytes, total_bytes,
      output ready
   );
endinterface

`default_nettype wire

@@ rtl/core/zlib_stream_integrity_checker_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none

// zlib stream integrity checker. Items arrive on req_bus: start (coded length
// and zlib header check in compressed mode), decoded data byte (counted against
// the per-stream and lifetime limits and folded into Adler-32) and end (trailer
// compare in compressed mode). Every item gives exactly one result on rsp_bus
// with the sticky status, the current Adler-32 and both byte counts. Throughput
// is one item per clock unless rsp_bus.ready stalls the result register. Items
// pass the input register and the result register, with the Adler-32 and count
// update done combinationally between them. The first error holds until reset.
// The user writes limits via csr_* only while idle; the block does not enforce it.
module zlib_stream_integrity_checker_unit (
   input  wire logic                               clock,
   input  wire logic                               reset,
   zsic_req_if.sink                                req_bus,
   zsic_rsp_if.source                              rsp_bus,
   input  wire logic                               csr_wr_en,
   input  wire logic [zsic_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  wire logic [zsic_pkg::CSR_DATA_W-1:0]    csr_wr_data
);

   localparam int SW = zsic_pkg::SUM_W;
   localparam int CW = zsic_pkg::STREAM_W;
   localparam int TW = zsic_pkg::TOTAL_W;

   // configuration
   logic [CW-1:0] stream_limit_ff;
   logic [TW-1:0] total_limit_ff;

   // input register
   logic                             in_valid_ff, in_valid_in;
   logic [zsic_pkg::FUNC_W-1:0]      in_func_ff;
   logic [7:0]                       in_cmf_ff;
   logic [7:0]                       in_flg_ff;
   logic                             in_comp_ff;
   logic [zsic_pkg::WORD_W-1:0]      in_clen_ff;
   logic [zsic_pkg::BYTE_W-1:0]      in_byte_ff;
   logic [zsic_pkg::WORD_W-1:0]      in_trailer_ff;

   // checker state
   logic [SW-1:0]                 sum_a_ff, sum_a_in;
   logic [SW-1:0]                 sum_b_ff, sum_b_in;
   logic [CW-1:0]                 stream_count_ff, stream_count_in;
   logic [TW-1:0]                 total_count_ff, total_count_in;
   zsic_pkg::status_type          error_ff, error_in;
   logic                          comp_mode_ff, comp_mode_in;

   // result register
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [zsic_pkg::STATUS_W-1:0] rsp_status_ff;
   logic [zsic_pkg::WORD_W-1:0]   rsp_checksum_ff;
   logic [CW-1:0]                 rsp_stream_ff;
   logic [TW-1:0]                 rsp_total_ff;

   logic req_xfer;
   logic advance;

   logic [SW:0]   a_sum;
   logic [SW-1:0] a_next;
   logic [SW:0]   b_sum;
   logic [SW-1:0] b_next;
   logic          over_limit;

   assign advance       = in_valid_ff && (!rsp_valid_ff || rsp_bus.ready);
   assign req_bus.ready = !in_valid_ff || advance;
   assign req_xfer      = req_bus.valid && req_bus.ready;

   assign in_valid_in  = req_xfer ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
   assign rsp_valid_in = advance ? 1'b1 : (rsp_bus.ready ? 1'b0 : rsp_valid_ff);

   // Adler-32 byte step and limit check: each sum stays below twice the modulus
   always_comb begin
      a_sum  = {1'b0, sum_a_ff} + {{(SW + 1 - zsic_pkg::BYTE_W){1'b0}}, in_byte_ff};
      a_next = (a_sum >= zsic_pkg::ADLER_MOD) ? SW'(a_sum - zsic_pkg::ADLER_MOD)
                                              : a_sum[SW-1:0];
      b_sum  = {1'b0, sum_b_ff} + {1'b0, a_next};
      b_next = (b_sum >= zsic_pkg::ADLER_MOD) ? SW'(b_sum - zsic_pkg::ADLER_MOD)
                                              : b_sum[SW-1:0];
      over_limit = (({1'b0, stream_count_ff} + (CW + 1)'(1)) > {1'b0, stream_limit_ff})
                || (({1'b0, total_count_ff} + (TW + 1)'(1)) > {1'b0, total_limit_ff});
   end

   always_comb begin
      sum_a_in        = sum_a_ff;
      sum_b_in        = sum_b_ff;
      stream_count_in = stream_count_ff;
      total_count_in  = total_count_ff;
      error_in        = error_ff;
      comp_mode_in    = comp_mode_ff;
      if (error_ff == zsic_pkg::STATUS_OK) begin
         case (zsic_pkg::func_type'(in_func_ff))
            zsic_pkg::FUNC_START: begin
               stream_count_in = '0;
               sum_a_in        = SW'(1);
               sum_b_in        = '0;
               comp_mode_in    = in_comp_ff;
               if (in_comp_ff) begin
                  if (in_clen_ff < zsic_pkg::MIN_CODED_LENGTH) begin
                     error_in = zsic_pkg::STATUS_INVALID;
                  end else if (!zsic_pkg::header_ok(in_cmf_ff, in_flg_ff)) begin
                     error_in = zsic_pkg::STATUS_UNSUPPORTED;
                  end
               end
            end
            zsic_pkg::FUNC_DATA: begin
               if (over_limit) begin
                  error_in = zsic_pkg::STATUS_LIMIT;
               end else begin
                  stream_count_in = stream_count_ff + CW'(1);
                  total_count_in  = total_count_ff + TW'(1);
                  sum_a_in        = a_next;
                  sum_b_in        = b_next;
               end
            end
            zsic_pkg::FUNC_END: begin
               if (comp_mode_ff && (in_trailer_ff != {sum_b_ff, sum_a_ff})) begin
                  error_in = zsic_pkg::STATUS_INVALID;
               end
            end
            default: begin
               // unused code: state reported unchanged
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stream_limit_ff <= zsic_pkg::STREAM_LIMIT_RESET;
         total_limit_ff  <= zsic_pkg::TOTAL_LIMIT_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            zsic_pkg::CSR_STREAM_BYTE_LIMIT: stream_limit_ff <= csr_wr_data[CW-1:0];
            zsic_pkg::CSR_TOTAL_BYTE_LIMIT:  total_limit_ff  <= csr_wr_data[TW-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff     <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         sum_a_ff        <= SW'(1);
         sum_b_ff        <= '0;
         stream_count_ff <= '0;
         total_count_ff  <= '0;
         error_ff        <= zsic_pkg::STATUS_OK;
         comp_mode_ff    <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (advance) begin
            sum_a_ff        <= sum_a_in;
            sum_b_ff        <= sum_b_in;
            stream_count_ff <= stream_count_in;
            total_count_ff  <= total_count_in;
            error_ff        <= error_in;
            comp_mode_ff    <= comp_mode_in;
         end
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         in_func_ff    <= req_bus.func;
         in_cmf_ff     <= req_bus.header_cmf;
         in_flg_ff     <= req_bus.header_flg;
         in_comp_ff    <= req_bus.is_compressed;
         in_clen_ff    <= req_bus.coded_length;
         in_byte_ff    <= req_bus.data_byte;
         in_trailer_ff <= req_bus.trailer_word;
      end
      if (advance) begin
         rsp_status_ff   <= error_in;
         rsp_checksum_ff <= {sum_b_in, sum_a_in};
         rsp_stream_ff   <= stream_count_in;
         rsp_total_ff    <= total_count_in;
      end
   end

   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.status       = rsp_status_ff;
   assign rsp_bus.checksum     = rsp_checksum_ff;
   assign rsp_bus.stream_bytes = rsp_stream_ff;
   assign rsp_bus.total_bytes  = rsp_total_ff;

endmodule

`default_nettype wire

@@ rtl/core/zsic_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none

`include "zlib_stream_integrity_checker_unit_assert.svh"

module zsic_checker (
   input wire logic                              clock,
   input wire logic                              reset,
   input wire logic                              rsp_valid,
   input wire logic                              rsp_ready,
   input wire logic [zsic_pkg::STATUS_W-1:0]     rsp_status,
   input wire logic [zsic_pkg::STREAM_W-1:0]     rsp_stream_bytes,
   input wire logic [zsic_pkg::TOTAL_W-1:0]      rsp_total_bytes
);

   logic                          err_seen_ff;
   logic [zsic_pkg::STATUS_W-1:0] err_code_ff;
   logic                          rsp_xfer;

   assign rsp_xfer = rsp_valid && rsp_ready;

   // remember the first error status seen on a result transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         err_seen_ff <= 1'b0;
         err_code_ff <= zsic_pkg::STATUS_OK;
      end else if (rsp_xfer && !err_seen_ff && (rsp_status != zsic_pkg::STATUS_OK)) begin
         err_seen_ff <= 1'b1;
         err_code_ff <= rsp_status;
      end
   end

   `ZSIC_ASSERT_NEXT(a_rsp_held, clock, reset, rsp_valid && !rsp_ready, rsp_valid, "result dropped before transfer")
   `ZSIC_ASSERT_SAME(a_error_sticky, clock, reset, rsp_xfer && err_seen_ff, rsp_status == err_code_ff, "error status changed after first error")
   `ZSIC_ASSERT_SAME(a_stream_within_total, clock, reset, rsp_xfer, ({4'd0, rsp_stream_bytes} <= rsp_total_bytes), "stream byte count above lifetime count")
   `ZSIC_ASSERT_ALWAYS_NEXT(a_reset_idle, clock, reset, !rsp_valid, "result valid right after reset")

endmodule

bind zlib_stream_integrity_checker_unit zsic_checker u_zsic_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_bus.valid),
   .rsp_ready        (rsp_bus.ready),
   .rsp_status       (rsp_bus.status),
   .rsp_stream_bytes (rsp_bus.stream_bytes),
   .rsp_total_bytes  (rsp_bus.total_bytes)
);

`default_nettype wire
